// ===== rtl/vfo_pkg.sv =====
// Shared constants, register indexes, status codes, and request and result types.
package vfo_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int FRAC_BITS      = 14;
  localparam int OUT_BITS       = 16;
  localparam int REG_BITS       = 31;
  localparam int QUOT_BITS      = 15;
  localparam int ONE_Q          = 2 ** FRAC_BITS;

  // register indexes
  localparam logic [0:0] REG_MIN_LENGTH_SQ  = 1'b0;
  localparam logic [0:0] REG_UNIT_TOLERANCE = 1'b1;

  localparam logic [REG_BITS-1:0] MIN_LENGTH_SQ_RESET  = 31'd268;
  localparam logic [REG_BITS-1:0] UNIT_TOLERANCE_RESET = 31'd268435;

  // status codes
  localparam logic [2:0] STATUS_OK           = 3'd0;
  localparam logic [2:0] STATUS_ZERO_NORMAL  = 3'd1;
  localparam logic [2:0] STATUS_NON_UNIT     = 3'd2;
  localparam logic [2:0] STATUS_BAD_HAND     = 3'd3;
  localparam logic [2:0] STATUS_ZERO_TANGENT = 3'd4;
  localparam logic [2:0] STATUS_PARALLEL     = 3'd5;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] normal_x;
    logic signed [COMPONENT_BITS-1:0] normal_y;
    logic signed [COMPONENT_BITS-1:0] normal_z;
    logic                             tangent_present;
    logic signed [COMPONENT_BITS-1:0] tangent_x;
    logic signed [COMPONENT_BITS-1:0] tangent_y;
    logic signed [COMPONENT_BITS-1:0] tangent_z;
    logic signed [COMPONENT_BITS-1:0] handedness_in;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] unit_normal_x;
    logic signed [OUT_BITS-1:0] unit_normal_y;
    logic signed [OUT_BITS-1:0] unit_normal_z;
    logic signed [OUT_BITS-1:0] unit_tangent_x;
    logic signed [OUT_BITS-1:0] unit_tangent_y;
    logic signed [OUT_BITS-1:0] unit_tangent_z;
    logic                       handedness_out;
    logic [2:0]                 status;
  } out_item_t;

endpackage

// ===== rtl/vfo_pipe.sv =====
// Delay line with stage enable for sideband data.
module vfo_pipe #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  // shift on every advance
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ===== rtl/vfo_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module vfo_isqrt #(
  parameter int XW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [XW-1:0]   x,
  output logic [XW/2-1:0] root
);

  localparam int NS = XW / 2;

  logic [XW-1:0] rem_q   [NS];
  logic [XW-1:0] root_q  [NS];
  logic [XW-1:0] rem_in  [NS];
  logic [XW-1:0] root_in [NS];
  logic [XW-1:0] rem_nx  [NS];
  logic [XW-1:0] root_nx [NS];

  // one trial subtract per stage, bit weight fixed by stage position
  always_comb begin
    logic [XW-1:0] bitv;
    logic [XW-1:0] trial;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rem_in[k]  = x;
        root_in[k] = '0;
      end else begin
        rem_in[k]  = rem_q[k-1];
        root_in[k] = root_q[k-1];
      end
      bitv  = {{(XW-1){1'b0}}, 1'b1} << (XW - 2 - 2 * k);
      trial = root_in[k] + bitv;
      if (rem_in[k] >= trial) begin
        rem_nx[k]  = rem_in[k] - trial;
        root_nx[k] = (root_in[k] >> 1) + bitv;
      end else begin
        rem_nx[k]  = rem_in[k];
        root_nx[k] = root_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k]  <= rem_nx[k];
        root_q[k] <= root_nx[k];
      end
    end
  end

  assign root = root_q[NS-1][XW/2-1:0];

endmodule

// ===== rtl/vfo_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, MSB first.
module vfo_div #(
  parameter int AW = 32,
  parameter int QW = 15
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] num,
  input  logic [AW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [AW-1:0] rem_q  [QW];
  logic [AW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [AW-1:0] rem_in [QW];
  logic [AW-1:0] den_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic [AW-1:0] rem_nx [QW];
  logic [QW-1:0] quo_nx [QW];

  // compare against the divisor shifted to this stage's bit
  always_comb begin
    logic [AW-1:0] sh;
    logic          take;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        rem_in[j] = num;
        den_in[j] = den;
        quo_in[j] = '0;
      end else begin
        rem_in[j] = rem_q[j-1];
        den_in[j] = den_q[j-1];
        quo_in[j] = quo_q[j-1];
      end
      sh        = den_in[j] << (QW - 1 - j);
      take      = rem_in[j] >= sh;
      rem_nx[j] = take ? rem_in[j] - sh : rem_in[j];
      quo_nx[j] = {quo_in[j][QW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        rem_q[j] <= rem_nx[j];
        den_q[j] <= den_in[j];
        quo_q[j] <= quo_nx[j];
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

// ===== rtl/vertex_frame_orthonormalize.sv =====
// Top level: normal and tangent orthonormalization pipeline with config registers.
// Throughput: one request per cycle; the whole pipeline holds while the result is stalled.
// Depth is set by two square-root pipelines and two 15-stage divider pipelines, one bit
// per stage, with the tangent path waiting on the unit normal.
// Reset (synchronous) empties the pipeline and loads the register defaults.
module vertex_frame_orthonormalize (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  vfo_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output vfo_pkg::out_item_t               out_data,
  input  logic                             cfg_write,
  input  logic [0:0]                       cfg_index,
  input  logic [vfo_pkg::REG_BITS-1:0]     cfg_data
);

  localparam int W    = vfo_pkg::COMPONENT_BITS;
  localparam int FB   = vfo_pkg::FRAC_BITS;
  localparam int OB   = vfo_pkg::OUT_BITS;
  localparam int QB   = vfo_pkg::QUOT_BITS;
  localparam int RB   = vfo_pkg::REG_BITS;
  localparam int LNW  = 2 * W;
  localparam int ANW  = W + FB + 2;
  localparam int TPW  = W + FB + 1;
  localparam int DW   = TPW + 2;
  localparam int PRW  = OB + DW;
  localparam int PW   = W + 3;
  localparam int LPW  = 2 * PW;
  localparam int ATW  = PW + FB + 2;
  localparam int CMPW = (LPW > RB ? LPW : RB) + 1;
  localparam int LAT  = 43 + W + PW;

  localparam logic signed [W-1:0] ONE_W   = W'(vfo_pkg::ONE_Q);
  localparam logic signed [W-1:0] M_ONE_W = W'(-vfo_pkg::ONE_Q);

  function automatic logic [W-1:0] mag_n(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  function automatic logic [PW-1:0] mag_p(input logic [PW-1:0] v);
    return v[PW-1] ? (~v + PW'(1)) : v;
  endfunction

  // quotient to signed unit component, clamped to one
  function automatic logic signed [OB-1:0] to_unit(input logic [QB-1:0] q, input logic neg);
    logic [OB-1:0] v;
    v = (q > QB'(vfo_pkg::ONE_Q)) ? OB'(vfo_pkg::ONE_Q) : OB'(q);
    return neg ? -$signed(v) : $signed(v);
  endfunction

  // n_i*(n.t) back to Q.14, rounded half away from zero
  function automatic logic signed [PW-1:0] round_proj(input logic signed [PRW-1:0] x);
    logic [PRW:0]  m;
    logic [PW-1:0] r;
    m = x[PRW-1] ? -((PRW+1)'(x)) : (PRW+1)'(x);
    m = m + ((PRW+1)'(1) << (2 * FB - 1));
    r = PW'(m >> (2 * FB));
    return x[PRW-1] ? -$signed(r) : $signed(r);
  endfunction

  // configuration registers
  logic [RB-1:0] min_length_sq;
  logic [RB-1:0] unit_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length_sq  <= vfo_pkg::MIN_LENGTH_SQ_RESET;
      unit_tolerance <= vfo_pkg::UNIT_TOLERANCE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vfo_pkg::REG_MIN_LENGTH_SQ:  min_length_sq  <= cfg_data;
        vfo_pkg::REG_UNIT_TOLERANCE: unit_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance and valid line
  logic           en;
  logic [LAT-1:0] vld;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage 1: request register
  vfo_pkg::in_item_t in_q;
  always_ff @(posedge clk) begin
    if (en) begin
      in_q <= in_data;
    end
  end

  logic [2:0][W-1:0] n1;
  logic [2:0][W-1:0] t1;
  assign n1 = {in_q.normal_z, in_q.normal_y, in_q.normal_x};
  assign t1 = {in_q.tangent_z, in_q.tangent_y, in_q.tangent_x};

  // stage 2: magnitudes and squares
  logic [2:0][W-1:0]   nmag2;
  logic [2:0]          nneg2;
  logic [LNW-1:0]      nsq2 [3];
  logic [LNW-1:0]      tsq2 [3];
  logic                bw2, hand2, pres2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nmag2[i] <= mag_n(n1[i]);
        nneg2[i] <= n1[i][W-1];
        nsq2[i]  <= LNW'(mag_n(n1[i])) * LNW'(mag_n(n1[i]));
        tsq2[i]  <= LNW'(mag_n(t1[i])) * LNW'(mag_n(t1[i]));
      end
      bw2   <= (in_q.handedness_in != ONE_W) && (in_q.handedness_in != M_ONE_W);
      hand2 <= in_q.handedness_in[W-1];
      pres2 <= in_q.tangent_present;
    end
  end

  // stage 3: squared lengths
  logic [LNW-1:0] ln3, lt3;
  logic           bw3, hand3, pres3;

  always_ff @(posedge clk) begin
    if (en) begin
      ln3   <= nsq2[0] + nsq2[1] + nsq2[2];
      lt3   <= tsq2[0] + tsq2[1] + tsq2[2];
      bw3   <= bw2;
      hand3 <= hand2;
      pres3 <= pres2;
    end
  end

  // stage 4: length checks, flags = {zn, nu, bw, zt, pres, hand}
  logic [5:0]    flags4;
  logic [CMPW-1:0] lnx, one_sq, ndiff;

  always_comb begin
    lnx    = CMPW'(ln3);
    one_sq = CMPW'(1) << (2 * FB);
    ndiff  = (lnx > one_sq) ? lnx - one_sq : one_sq - lnx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags4 <= {lnx <= CMPW'(min_length_sq), ndiff > CMPW'(unit_tolerance), bw3,
                 CMPW'(lt3) <= CMPW'(min_length_sq), pres3, hand3};
    end
  end

  // normal square root
  logic [W-1:0] sn;
  vfo_isqrt #(.XW(LNW)) u_sqrt_n (.clk(clk), .en(en), .x(ln3), .root(sn));

  logic [2:0][W-1:0] nmag_d;
  vfo_pipe #(.WIDTH(3 * W), .DEPTH(W + 1)) u_nmag_pipe (
    .clk(clk), .en(en), .d(nmag2), .q(nmag_d));

  logic [2:0] nneg_d;
  vfo_pipe #(.WIDTH(3), .DEPTH(W + 17)) u_nneg_pipe (
    .clk(clk), .en(en), .d(nneg2), .q(nneg_d));

  // normal divider operands
  logic [ANW-1:0] num_n [3];
  logic [ANW-1:0] den_n;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_n[i] <= (ANW'(nmag_d[i]) << FB) + ANW'(sn >> 1);
      end
      den_n <= (sn == '0) ? ANW'(1) : ANW'(sn);
    end
  end

  logic [QB-1:0] qn [3];
  for (genvar i = 0; i < 3; i++) begin : g_div_n
    vfo_div #(.AW(ANW), .QW(QB)) u_div (
      .clk(clk), .en(en), .num(num_n[i]), .den(den_n), .quo(qn[i]));
  end

  // unit normal
  logic [2:0][OB-1:0] un20;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        un20[i] <= to_unit(qn[i], nneg_d[i]);
      end
    end
  end

  logic [2:0][W-1:0] t20, t23;
  vfo_pipe #(.WIDTH(3 * W), .DEPTH(W + 19)) u_t_pipe (
    .clk(clk), .en(en), .d(t1), .q(t20));
  vfo_pipe #(.WIDTH(3 * W), .DEPTH(3)) u_t_pipe2 (
    .clk(clk), .en(en), .d(t20), .q(t23));

  // dot product n.t
  logic signed [TPW-1:0] tp21 [3];
  logic signed [DW-1:0]  d22;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tp21[i] <= TPW'($signed(un20[i])) * TPW'($signed(t20[i]));
      end
      d22 <= DW'(tp21[0]) + DW'(tp21[1]) + DW'(tp21[2]);
    end
  end

  logic [2:0][OB-1:0] un22;
  vfo_pipe #(.WIDTH(3 * OB), .DEPTH(2)) u_un_pipe (
    .clk(clk), .en(en), .d(un20), .q(un22));

  // projection and orthogonal remainder
  logic signed [PRW-1:0] ud23 [3];
  logic [2:0][PW-1:0]    p24;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ud23[i] <= PRW'($signed(un22[i])) * d22;
        p24[i]  <= PW'($signed(t23[i])) - round_proj(ud23[i]);
      end
    end
  end

  // remainder squares and length
  logic [2:0][PW-1:0] pmag25;
  logic [2:0]         pneg25;
  logic [LPW-1:0]     psq25 [3];
  logic [LPW-1:0]     lp26;
  logic               zp27;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pmag25[i] <= mag_p(p24[i]);
        pneg25[i] <= p24[i][PW-1];
        psq25[i]  <= LPW'(mag_p(p24[i])) * LPW'(mag_p(p24[i]));
      end
      lp26 <= psq25[0] + psq25[1] + psq25[2];
      zp27 <= CMPW'(lp26) <= CMPW'(min_length_sq);
    end
  end

  // tangent square root and divider
  logic [PW-1:0] sp;
  vfo_isqrt #(.XW(LPW)) u_sqrt_t (.clk(clk), .en(en), .x(lp26), .root(sp));

  logic [2:0][PW-1:0] pmag_d;
  vfo_pipe #(.WIDTH(3 * PW), .DEPTH(PW + 1)) u_pmag_pipe (
    .clk(clk), .en(en), .d(pmag25), .q(pmag_d));

  logic [ATW-1:0] num_t [3];
  logic [ATW-1:0] den_t;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_t[i] <= (ATW'(pmag_d[i]) << FB) + ATW'(sp >> 1);
      end
      den_t <= (sp == '0) ? ATW'(1) : ATW'(sp);
    end
  end

  logic [QB-1:0] qt [3];
  for (genvar i = 0; i < 3; i++) begin : g_div_t
    vfo_div #(.AW(ATW), .QW(QB)) u_div (
      .clk(clk), .en(en), .num(num_t[i]), .den(den_t), .quo(qt[i]));
  end

  // sideband aligned with the tangent quotient
  logic [5:0]         flags_f;
  logic               zp_f;
  logic [2:0]         pneg_f;
  logic [2:0][OB-1:0] un_f;

  vfo_pipe #(.WIDTH(6), .DEPTH(W + PW + 38)) u_flag_pipe (
    .clk(clk), .en(en), .d(flags4), .q(flags_f));
  vfo_pipe #(.WIDTH(1), .DEPTH(PW + 15)) u_zp_pipe (
    .clk(clk), .en(en), .d(zp27), .q(zp_f));
  vfo_pipe #(.WIDTH(3), .DEPTH(PW + 17)) u_pneg_pipe (
    .clk(clk), .en(en), .d(pneg25), .q(pneg_f));
  vfo_pipe #(.WIDTH(3 * OB), .DEPTH(PW + 22)) u_unf_pipe (
    .clk(clk), .en(en), .d(un20), .q(un_f));

  // final status and result register
  logic [2:0] status_c;
  logic       pres_f;

  always_comb begin
    pres_f = flags_f[1];
    if (flags_f[5]) begin
      status_c = vfo_pkg::STATUS_ZERO_NORMAL;
    end else if (flags_f[4]) begin
      status_c = vfo_pkg::STATUS_NON_UNIT;
    end else if (pres_f && flags_f[3]) begin
      status_c = vfo_pkg::STATUS_BAD_HAND;
    end else if (pres_f && flags_f[2]) begin
      status_c = vfo_pkg::STATUS_ZERO_TANGENT;
    end else if (pres_f && zp_f) begin
      status_c = vfo_pkg::STATUS_PARALLEL;
    end else begin
      status_c = vfo_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (status_c == vfo_pkg::STATUS_OK) begin
        out_data.unit_normal_x <= un_f[0];
        out_data.unit_normal_y <= un_f[1];
        out_data.unit_normal_z <= un_f[2];
      end else begin
        out_data.unit_normal_x <= '0;
        out_data.unit_normal_y <= '0;
        out_data.unit_normal_z <= '0;
      end
      if (status_c == vfo_pkg::STATUS_OK && pres_f) begin
        out_data.unit_tangent_x <= to_unit(qt[0], pneg_f[0]);
        out_data.unit_tangent_y <= to_unit(qt[1], pneg_f[1]);
        out_data.unit_tangent_z <= to_unit(qt[2], pneg_f[2]);
        out_data.handedness_out <= flags_f[0];
      end else begin
        out_data.unit_tangent_x <= '0;
        out_data.unit_tangent_y <= '0;
        out_data.unit_tangent_z <= '0;
        out_data.handedness_out <= 1'b0;
      end
      out_data.status <= status_c;
    end
  end

  // an error result carries no frame
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != vfo_pkg::STATUS_OK) |->
      (out_data.unit_normal_x == '0 && out_data.unit_normal_y == '0 &&
       out_data.unit_normal_z == '0 && out_data.unit_tangent_x == '0 &&
       out_data.unit_tangent_y == '0 && out_data.unit_tangent_z == '0))
    else $error("error result with nonzero frame");

  // a good normal never collapses to zero
  a_ok_normal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == vfo_pkg::STATUS_OK) |->
      (out_data.unit_normal_x != '0 || out_data.unit_normal_y != '0 ||
       out_data.unit_normal_z != '0))
    else $error("ok result with zero normal");

  // negative handedness only on a good result
  a_hand_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.handedness_out) |-> (out_data.status == vfo_pkg::STATUS_OK))
    else $error("handedness set on error result");

  // a held pipeline keeps its valid line
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vld))
    else $error("pipeline moved while stalled");

endmodule
